[sv/iqdqp_pkg.sv]
// Package for the IQ decimate, quantize and pack block.
// Holds widths, defaults, register indexes and the configuration struct.
// Depends on nothing.
package iqdqp_pkg;

    localparam int RAW_W        = 24;
    localparam int HALF_W       = 12;
    localparam int WORD_W       = 32;
    localparam int NIB_W        = 4;
    localparam int NIBS_PER_WORD = WORD_W / NIB_W;
    localparam int PACK_W       = WORD_W - NIB_W;
    localparam int SQ_W         = 2 * HALF_W - 1;
    localparam int OFF_W        = 4;

    localparam int DECIMATION_DEF      = 8;
    localparam int WORDS_PER_FRAME_DEF = 250;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IQ_BIT_OFFSET = CFG_IDX_W'(1);

    localparam logic [OFF_W-1:0] IQ_BIT_OFFSET_RST = OFF_W'(6);

    localparam logic [2:0] MAG_FLIP = 3'd7;

    typedef struct packed {
        logic             angle_mode;
        logic [OFF_W-1:0] iq_bit_offset;
    } t_cfg;

endpackage

[sv/iqdqp_ifs.sv]
// Handshake interfaces for the IQ decimate, quantize and pack block:
// raw sample stream, packed word stream and register write channel.
// Depends on iqdqp_pkg.
interface iqdqp_in_if;
    import iqdqp_pkg::*;
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface

interface iqdqp_out_if;
    import iqdqp_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] packed_word;
    logic              frame_end;

    modport source (output valid, output packed_word, output frame_end, input ready);
    modport sink   (input valid, input packed_word, input frame_end, output ready);
endinterface

interface iqdqp_cfg_if;
    import iqdqp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/iqdqp_front.sv]
// Front end: accepts raw capture words and keeps one of every DECIMATION.
// Kept words go on to the queue. Depends on iqdqp_pkg and iqdqp_ifs.
module iqdqp_front
    import iqdqp_pkg::*;
#(
    parameter int DECIMATION = DECIMATION_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    iqdqp_in_if.sink     i_in,
    iqdqp_in_if.source   o_kept
);

    localparam int PH_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(DECIMATION - 1);

    logic [PH_W-1:0] r_phase;
    logic [PH_W-1:0] n_phase;
    logic            w_keep;
    logic            w_accept;

    assign w_keep           = (r_phase == '0);
    assign o_kept.valid     = i_in.valid && w_keep;
    assign o_kept.raw_sample = i_in.raw_sample;
    assign i_in.ready       = !w_keep || o_kept.ready;
    assign w_accept         = i_in.valid && i_in.ready;

    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            n_phase = (r_phase == PH_LAST) ? '0 : r_phase + PH_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

[sv/iqdqp_queue.sv]
// Short queue between front and back end so each side stalls on its own.
// Holds QUEUE_DEPTH kept raw words. Depends on iqdqp_pkg and iqdqp_ifs.
module iqdqp_queue
    import iqdqp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    iqdqp_in_if.sink     i_push,
    iqdqp_in_if.source   o_pop
);

    logic [RAW_W-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;
    logic              w_pop;

    assign i_push.ready     = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_pop.valid      = (r_count != '0);
    assign o_pop.raw_sample = r_mem[r_rd_ptr];
    assign w_push           = i_push.valid && i_push.ready;
    assign w_pop            = o_pop.valid && o_pop.ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.raw_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[sv/iqdqp_back.sv]
// Back end: squares I and Q, forms the nibble, packs eight nibbles per word
// and flags the frame end. Depends on iqdqp_pkg and iqdqp_ifs.
module iqdqp_back
    import iqdqp_pkg::*;
#(
    parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    iqdqp_in_if.sink      i_kept,
    iqdqp_out_if.source   o_out
);

    localparam int WC_W = (WORDS_PER_FRAME > 1) ? $clog2(WORDS_PER_FRAME) : 1;
    localparam logic [WC_W-1:0] WC_LAST = WC_W'(WORDS_PER_FRAME - 1);
    localparam logic [2:0] NIB_LAST = 3'(NIBS_PER_WORD - 1);

    // stage 1: squares and IQ bit pick
    logic signed [HALF_W-1:0]   w_i;
    logic signed [HALF_W-1:0]   w_q;
    logic signed [2*HALF_W-1:0] w_i2_full;
    logic signed [2*HALF_W-1:0] w_q2_full;
    logic [RAW_W+1:0]           w_raw_i_ext;
    logic [RAW_W+5:0]           w_raw_q_ext;
    logic [OFF_W:0]             w_q_pos;
    logic [1:0]                 w_ib;
    logic [1:0]                 w_qb;

    logic              r_s1_valid;
    logic [SQ_W-1:0]   r_s1_i2;
    logic [SQ_W-1:0]   r_s1_q2;
    logic              r_s1_is;
    logic              r_s1_qs;
    logic [NIB_W-1:0]  r_s1_iq_nib;
    logic              r_s1_angle;

    // stage 2: pack and output
    logic              w_ge0;
    logic              w_ge1;
    logic              w_ge2;
    logic [2:0]        w_mag;
    logic [NIB_W-1:0]  w_nib;
    logic              w_out_free;
    logic              w_s1_go;
    logic              w_s1_load;
    logic              w_emit;

    logic [PACK_W-1:0] r_packer;
    logic [2:0]        r_nib_cnt;
    logic [WC_W-1:0]   r_word_cnt;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_word;
    logic              r_out_last;

    assign w_i       = i_kept.raw_sample[HALF_W-1:0];
    assign w_q       = i_kept.raw_sample[RAW_W-1:HALF_W];
    assign w_i2_full = w_i * w_i;
    assign w_q2_full = w_q * w_q;

    assign w_raw_i_ext = {2'b00, i_kept.raw_sample};
    assign w_raw_q_ext = {6'b000000, i_kept.raw_sample};
    assign w_q_pos     = {1'b0, i_cfg.iq_bit_offset} + (OFF_W+1)'(HALF_W);
    assign w_ib        = 2'(w_raw_i_ext >> i_cfg.iq_bit_offset);
    assign w_qb        = 2'(w_raw_q_ext >> w_q_pos);

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s1_go    = r_s1_valid && ((r_nib_cnt != NIB_LAST) || w_out_free);
    assign w_s1_load  = !r_s1_valid || w_s1_go;
    assign i_kept.ready = w_s1_load;
    assign w_emit     = w_s1_go && (r_nib_cnt == NIB_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_load) begin
            r_s1_valid <= i_kept.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_load && i_kept.valid) begin
            r_s1_i2     <= SQ_W'(w_i2_full);
            r_s1_q2     <= SQ_W'(w_q2_full);
            r_s1_is     <= w_i[HALF_W-1];
            r_s1_qs     <= w_q[HALF_W-1];
            r_s1_iq_nib <= {w_qb, w_ib};
            r_s1_angle  <= i_cfg.angle_mode;
        end
    end

    always_comb begin
        w_ge0 = (r_s1_q2 >= (r_s1_i2 >> 2));
        w_ge1 = (r_s1_q2 >= r_s1_i2);
        w_ge2 = ({2'b00, r_s1_q2} >= {r_s1_i2, 2'b00});
        w_mag = 3'(w_ge0) + 3'(w_ge1) + 3'(w_ge2);
        if (r_s1_qs != r_s1_is) begin
            w_mag = w_mag ^ MAG_FLIP;
        end
        w_nib = r_s1_angle ? {r_s1_qs, w_mag} : r_s1_iq_nib;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packer    <= '0;
            r_nib_cnt   <= '0;
            r_word_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_go) begin
                if (r_nib_cnt == NIB_LAST) begin
                    r_packer   <= '0;
                    r_nib_cnt  <= '0;
                    r_word_cnt <= (r_word_cnt == WC_LAST) ? '0 : r_word_cnt + WC_W'(1);
                end else begin
                    for (int k = 0; k < NIBS_PER_WORD - 1; k++) begin
                        if (r_nib_cnt == 3'(k)) begin
                            r_packer[k*NIB_W +: NIB_W] <= w_nib;
                        end
                    end
                    r_nib_cnt <= r_nib_cnt + 3'd1;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_word <= {w_nib, r_packer};
            r_out_last <= (r_word_cnt == WC_LAST);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.packed_word = r_out_word;
    assign o_out.frame_end   = r_out_last;

endmodule

[sv/iq_decimate_quantize_pack.sv]
// Top level of the IQ decimate, quantize and pack block.
// Holds the configuration registers and ties front, queue and back together.
// Depends on iqdqp_pkg, iqdqp_ifs, iqdqp_front, iqdqp_queue and iqdqp_back.
//
// Usage:
//   i_in takes one 24-bit capture word per cycle while ready (I in bits 11:0, Q in
//   bits 23:12, both signed). One word of every DECIMATION is kept and
//   turned into a 4-bit nibble: two I bits and two Q bits at the configured
//   offset, or a 16-sector phase code in angle mode.
//   o_out delivers one 32-bit word per eight kept samples, earliest nibble
//   in bits 3:0; frame_end marks every WORDS_PER_FRAME-th word.
//   i_cfg writes register 0 (angle_mode) and 1 (iq_bit_offset); it is always
//   ready, other indexes are dropped. Write only while the block is idle.
// Timing:
//   One input word per cycle sustained while o_out is ready. A word reaches
//   o_out after its eighth kept sample passes the queue and the squaring
//   stage register, then packing loads the output register.
// Reset and stall:
//   Reset clears counters, packer and queue; angle_mode goes to 0 and
//   iq_bit_offset to 6. When o_out stalls, a finished word holds in the output
//   register, packing continues up to the next word, then the 4-entry queue
//   fills and i_in deasserts ready.
module iq_decimate_quantize_pack
    import iqdqp_pkg::*;
#(
    parameter int DECIMATION      = DECIMATION_DEF,
    parameter int WORDS_PER_FRAME = WORDS_PER_FRAME_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iqdqp_in_if.sink      i_in,
    iqdqp_cfg_if.sink     i_cfg,
    iqdqp_out_if.source   o_out
);

    t_cfg r_cfg;

    iqdqp_in_if w_kept ();
    iqdqp_in_if w_queued ();

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_mode    <= 1'b0;
            r_cfg.iq_bit_offset <= IQ_BIT_OFFSET_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ANGLE_MODE:    r_cfg.angle_mode    <= i_cfg.data[0];
                REG_IQ_BIT_OFFSET: r_cfg.iq_bit_offset <= OFF_W'(i_cfg.data);
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    iqdqp_front #(
        .DECIMATION (DECIMATION)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_kept  (w_kept)
    );

    iqdqp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_kept),
        .o_pop   (w_queued)
    );

    iqdqp_back #(
        .WORDS_PER_FRAME (WORDS_PER_FRAME)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_kept  (w_queued),
        .o_out   (o_out)
    );

endmodule
